// ===== rtl/core/wph_pkg.sv =====
// ----------------------------------------------------------------------------
// wph_pkg
// Types and constants shared by the RIFF/WAVE 16-bit PCM header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package wph_pkg;

  localparam int unsigned OFFSET_WIDTH_DEF = 32;

  localparam logic [31:0] ID_RIFF = 32'h5249_4646;
  localparam logic [31:0] ID_WAVE = 32'h5741_5645;
  localparam logic [31:0] ID_FMT  = 32'h666d_7420;
  localparam logic [31:0] ID_DATA = 32'h6461_7461;

  localparam int unsigned FMT_MIN_LEN  = 16;
  localparam int unsigned FILE_HDR_LEN = 12;

  localparam logic [15:0] FMT_PCM     = 16'd1;
  localparam logic [15:0] PCM_BITS    = 16'd16;

  localparam int unsigned DIV_STEPS   = 31;
  localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    PH_FILE = 2'd0,
    PH_HDR  = 2'd1,
    PH_BODY = 2'd2,
    PH_PAD  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_FMT   = 2'd1,
    KIND_DATA  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_DIV  = 2'd1,
    BK_DONE = 2'd2
  } back_state_e;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       end_of_file;
  } wph_in_t;

  typedef struct packed {
    logic        valid_pcm16;
    logic [15:0] channel_count;
    logic [31:0] rate_hz;
    logic [31:0] data_offset;
    logic [31:0] data_bytes;
    logic [30:0] frame_count;
  } wph_out_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] chans;
    logic [31:0] rate;
    logic [31:0] offset;
    logic [31:0] length;
  } wph_job_t;

endpackage

`default_nettype wire

// ===== rtl/core/wav_pcm16_header_parser.sv =====
// ----------------------------------------------------------------------------
// wav_pcm16_header_parser
// RIFF/WAVE header parser: walks chunks byte by byte, reports 16-bit PCM
// format, data location and frame count after the last byte of a file.
//
//   channel  direction  payload    handshake
//   in       input      wph_in_t   in_valid_i / in_ready_o
//   out      output     wph_out_t  out_valid_o / out_ready_i
//
// One file byte per cycle through the chunk walker while in_ready_o is high.
// After its end-of-file byte a report passes the queue, a 31-step
// restoring divide for the frame count and the output register.
// Two pending reports fill the queue; in_ready_o then drops until one drains.
// Reset clears all control state at once; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module wav_pcm16_header_parser import wph_pkg::*; #(
  parameter int unsigned OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire wph_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output wph_out_t      out_data_o
);

  logic     push_valid, push_ready;
  wph_job_t push_data;
  logic     pop_valid, pop_ready;
  wph_job_t pop_data;

  wph_front #(
    .OFFSET_WIDTH(OFFSET_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .job_valid_o(push_valid),
    .job_ready_i(push_ready),
    .job_o      (push_data)
  );

  wph_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i (push_data),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_data)
  );

  wph_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(pop_valid),
    .job_ready_o(pop_ready),
    .job_i      (pop_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/wph_front.sv =====
// ----------------------------------------------------------------------------
// wph_front
// Byte-serial chunk walker; emits one report job on the end-of-file byte.
// ----------------------------------------------------------------------------
`default_nettype none

module wph_front import wph_pkg::*; #(
  parameter int unsigned OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire wph_in_t  in_data_i,
  output logic          job_valid_o,
  input  wire logic     job_ready_i,
  output wph_job_t      job_o
);

  logic [OFFSET_WIDTH-1:0] pos_q, pos_d;
  logic [OFFSET_WIDTH-1:0] body_start_q, body_start_d;
  logic [OFFSET_WIDTH-1:0] data_start_q, data_start_d;
  logic [31:0] recent_q, recent_d;
  logic        sig_q, sig_d;
  phase_e      phase_q, phase_d;
  kind_e       kind_q, kind_d;
  logic [31:0] len_q, len_d;
  logic [31:0] remain_q, remain_d;
  logic [2:0]  hdr_cnt_q, hdr_cnt_d;
  logic [4:0]  bidx_q, bidx_d;
  logic [47:0] pend_fmt_q, pend_fmt_d;
  logic [31:0] pend_rate_q, pend_rate_d;
  logic [47:0] saved_fmt_q, saved_fmt_d;
  logic [31:0] saved_rate_q, saved_rate_d;
  logic        data_found_q, data_found_d;
  logic [31:0] data_len_q, data_len_d;

  logic                    accept;
  logic                    parse_en;
  logic                    complete;
  kind_e                   cmp_kind;
  logic [31:0]             cmp_len;
  logic [OFFSET_WIDTH-1:0] cmp_start;
  logic [31:0]             hdr_len;
  logic                    ok;

  assign in_ready_o  = job_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign job_valid_o = accept && in_data_i.end_of_file;
  assign parse_en    = pos_q != {OFFSET_WIDTH{1'b1}};
  assign hdr_len     = {recent_d[7:0], recent_d[15:8], recent_d[23:16], recent_d[31:24]};

  always_comb begin
    pos_d        = pos_q;
    body_start_d = body_start_q;
    data_start_d = data_start_q;
    recent_d     = recent_q;
    sig_d        = sig_q;
    phase_d      = phase_q;
    kind_d       = kind_q;
    len_d        = len_q;
    remain_d     = remain_q;
    hdr_cnt_d    = hdr_cnt_q;
    bidx_d       = bidx_q;
    pend_fmt_d   = pend_fmt_q;
    pend_rate_d  = pend_rate_q;
    saved_fmt_d  = saved_fmt_q;
    saved_rate_d = saved_rate_q;
    data_found_d = data_found_q;
    data_len_d   = data_len_q;
    complete     = 1'b0;
    cmp_kind     = kind_q;
    cmp_len      = len_q;
    cmp_start    = body_start_q;
    ok           = 1'b0;
    job_o        = '0;

    if (accept && parse_en) begin
      pos_d    = pos_q + 1'b1;
      recent_d = {recent_q[23:0], in_data_i.file_byte};
      case (phase_q)
        PH_FILE: begin
          if (pos_q == OFFSET_WIDTH'(3)) begin
            sig_d = recent_d == ID_RIFF;
          end else if (pos_q == OFFSET_WIDTH'(FILE_HDR_LEN - 1)) begin
            sig_d     = sig_q && (recent_d == ID_WAVE);
            phase_d   = PH_HDR;
            hdr_cnt_d = '0;
          end
        end
        PH_HDR: begin
          hdr_cnt_d = hdr_cnt_q + 1'b1;
          if (hdr_cnt_q == 3'd3) begin
            if (recent_d == ID_FMT) begin
              kind_d = KIND_FMT;
            end else if (recent_d == ID_DATA) begin
              kind_d = KIND_DATA;
            end else begin
              kind_d = KIND_OTHER;
            end
          end else if (hdr_cnt_q == 3'd7) begin
            len_d        = hdr_len;
            body_start_d = pos_q + 1'b1;
            remain_d     = hdr_len;
            bidx_d       = '0;
            hdr_cnt_d    = '0;
            if (hdr_len == '0) begin
              complete  = 1'b1;
              cmp_len   = hdr_len;
              cmp_start = body_start_d;
              phase_d   = PH_HDR;
            end else begin
              phase_d = PH_BODY;
            end
          end
        end
        PH_BODY: begin
          if (kind_q == KIND_FMT) begin
            if (bidx_q < 5'd4) begin
              pend_fmt_d[8*bidx_q[1:0] +: 8] = in_data_i.file_byte;
            end else if (bidx_q < 5'd8) begin
              pend_rate_d[8*bidx_q[1:0] +: 8] = in_data_i.file_byte;
            end else if (bidx_q == 5'd14 || bidx_q == 5'd15) begin
              pend_fmt_d[32 + 8*bidx_q[0] +: 8] = in_data_i.file_byte;
            end
          end
          if (bidx_q != 5'd16) begin
            bidx_d = bidx_q + 1'b1;
          end
          remain_d = remain_q - 1'b1;
          if (remain_q == 32'd1) begin
            complete  = 1'b1;
            hdr_cnt_d = '0;
            phase_d   = len_q[0] ? PH_PAD : PH_HDR;
          end
        end
        default: begin
          hdr_cnt_d = '0;
          phase_d   = PH_HDR;
        end
      endcase
    end

    if (complete) begin
      if (cmp_kind == KIND_FMT && cmp_len >= 32'(FMT_MIN_LEN)) begin
        saved_fmt_d  = pend_fmt_d;
        saved_rate_d = pend_rate_d;
      end else if (cmp_kind == KIND_DATA) begin
        data_found_d = 1'b1;
        data_start_d = cmp_start;
        data_len_d   = cmp_len;
      end
    end

    ok = sig_d && (phase_d != PH_FILE) && (saved_fmt_d[15:0] == FMT_PCM) &&
         (saved_fmt_d[47:32] == PCM_BITS) && (saved_fmt_d[31:16] != '0) &&
         data_found_d;
    if (ok) begin
      job_o.ok     = 1'b1;
      job_o.chans  = saved_fmt_d[31:16];
      job_o.rate   = saved_rate_d;
      job_o.offset = 32'(data_start_d);
      job_o.length = data_len_d;
    end

    if (job_valid_o) begin
      pos_d        = '0;
      recent_d     = '0;
      sig_d        = 1'b0;
      phase_d      = PH_FILE;
      kind_d       = KIND_OTHER;
      len_d        = '0;
      remain_d     = '0;
      hdr_cnt_d    = '0;
      bidx_d       = '0;
      pend_fmt_d   = '0;
      pend_rate_d  = '0;
      saved_fmt_d  = '0;
      saved_rate_d = '0;
      data_found_d = 1'b0;
      data_start_d = '0;
      data_len_d   = '0;
      body_start_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      body_start_q <= '0;
      data_start_q <= '0;
      recent_q     <= '0;
      sig_q        <= 1'b0;
      phase_q      <= PH_FILE;
      kind_q       <= KIND_OTHER;
      len_q        <= '0;
      remain_q     <= '0;
      hdr_cnt_q    <= '0;
      bidx_q       <= '0;
      pend_fmt_q   <= '0;
      pend_rate_q  <= '0;
      saved_fmt_q  <= '0;
      saved_rate_q <= '0;
      data_found_q <= 1'b0;
      data_len_q   <= '0;
    end else begin
      pos_q        <= pos_d;
      body_start_q <= body_start_d;
      data_start_q <= data_start_d;
      recent_q     <= recent_d;
      sig_q        <= sig_d;
      phase_q      <= phase_d;
      kind_q       <= kind_d;
      len_q        <= len_d;
      remain_q     <= remain_d;
      hdr_cnt_q    <= hdr_cnt_d;
      bidx_q       <= bidx_d;
      pend_fmt_q   <= pend_fmt_d;
      pend_rate_q  <= pend_rate_d;
      saved_fmt_q  <= saved_fmt_d;
      saved_rate_q <= saved_rate_d;
      data_found_q <= data_found_d;
      data_len_q   <= data_len_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/wph_queue.sv =====
// ----------------------------------------------------------------------------
// wph_queue
// Two-entry job queue between the chunk walker and the report stage.
// ----------------------------------------------------------------------------
`default_nettype none

module wph_queue import wph_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_valid_i,
  output logic          push_ready_o,
  input  wire wph_job_t push_data_i,
  output logic          pop_valid_o,
  input  wire logic     pop_ready_i,
  output wph_job_t      pop_data_o
);

  wph_job_t   slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign push_ready_o = count_q != 2'd2;
  assign pop_valid_o  = count_q != 2'd0;
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/wph_back.sv =====
// ----------------------------------------------------------------------------
// wph_back
// Report stage: bit-serial frame count divide and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module wph_back import wph_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     job_valid_i,
  output logic          job_ready_o,
  input  wire wph_job_t job_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output wph_out_t      out_data_o
);

  back_state_e          state_q, state_d;
  wph_job_t             job_q, job_d;
  logic [30:0]          quo_q, quo_d;
  logic [15:0]          rem_q, rem_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  wph_out_t             out_q, out_d;
  logic [16:0]          rem_sh;
  logic                 fits;

  assign rem_sh      = {rem_q, quo_q[30]};
  assign fits        = rem_sh >= {1'b0, job_q.chans};
  assign job_ready_o = state_q == BK_IDLE;
  assign out_valid_o = state_q == BK_DONE;
  assign out_data_o  = out_q;

  always_comb begin
    state_d = state_q;
    job_d   = job_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    out_d   = out_q;
    case (state_q)
      BK_IDLE: begin
        if (job_valid_i) begin
          job_d   = job_i;
          quo_d   = job_i.length[31:1];
          rem_d   = '0;
          cnt_d   = DIV_CNT_W'(DIV_STEPS - 1);
          state_d = BK_DIV;
        end
      end
      BK_DIV: begin
        rem_d = fits ? 16'(rem_sh - {1'b0, job_q.chans}) : rem_sh[15:0];
        quo_d = {quo_q[29:0], fits};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          out_d.valid_pcm16   = job_q.ok;
          out_d.channel_count = job_q.chans;
          out_d.rate_hz       = job_q.rate;
          out_d.data_offset   = job_q.offset;
          out_d.data_bytes    = job_q.length;
          out_d.frame_count   = job_q.ok ? quo_d : '0;
          state_d             = BK_DONE;
        end
      end
      BK_DONE: begin
        if (out_ready_i) begin
          state_d = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    cnt_q <= cnt_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/wph_checker.sv =====
// ----------------------------------------------------------------------------
// wph_checker
// Port-level checks on the input and report channels of the header parser.
// ----------------------------------------------------------------------------
`default_nettype none

module wph_checker import wph_pkg::*; (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_ready_o,
  input wire wph_in_t  in_data_i,
  input wire logic     out_valid_o,
  input wire logic     out_ready_i,
  input wire wph_out_t out_data_o
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("input item dropped or changed while stalled");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("report dropped or changed while stalled");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.valid_pcm16 |->
      out_data_o.channel_count == '0 && out_data_o.rate_hz == '0 &&
      out_data_o.data_offset == '0 && out_data_o.data_bytes == '0 &&
      out_data_o.frame_count == '0)
    else $error("invalid report carries nonzero fields");

  a_valid_chans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.valid_pcm16 |-> out_data_o.channel_count != '0)
    else $error("valid report with zero channels");

  a_frames_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.frame_count <= out_data_o.data_bytes[31:1])
    else $error("frame count exceeds data length");

endmodule

bind wav_pcm16_header_parser wph_checker u_wph_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

`default_nettype wire

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: RIFF/WAVE 16-bit PCM header parser testbench
// Streams whole files into the parser byte by byte, predicts each end-of-file
// report with a cycle-free model of the chunk walker, and checks every report
// field by field. Covers directed corner files, a long receiver hold-off and
// random files under several sender and receiver idling mixes.
// ----------------------------------------------------------------------------
module tb_top import wph_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] POS_MAX = (64'd1 << OFFSET_WIDTH_DEF) - 64'd1;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  wph_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  wph_out_t out_data;

  logic     in_fire = 1'b0;
  logic     rx_hold = 1'b0;
  logic     hold_go = 1'b0;
  int       send_gap_pct = 0;
  int       recv_stall_pct = 0;
  int       err_cnt = 0;
  int       reports_seen = 0;

  wph_in_t  byte_q[$];
  wph_out_t report_q[$];
  logic [7:0] file_img[$];

  // parser state
  logic [63:0] wv_pos;
  logic [31:0] wv_recent;
  logic        wv_sig_ok;
  phase_e      wv_phase;
  kind_e       wv_kind;
  logic [31:0] wv_clen;
  logic [63:0] wv_cend;
  logic [63:0] wv_pend_fmt;
  logic [31:0] wv_pend_rate;
  logic [63:0] wv_sav_fmt;
  logic [31:0] wv_sav_rate;
  logic        wv_have_data;
  logic [63:0] wv_dstart;
  logic [31:0] wv_dlen;

  wav_pcm16_header_parser uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always #1 clk_i = ~clk_i;

  task automatic wav_clear();
    wv_pos       = '0;
    wv_recent    = '0;
    wv_sig_ok    = 1'b0;
    wv_phase     = PH_FILE;
    wv_kind      = KIND_OTHER;
    wv_clen      = '0;
    wv_cend      = '0;
    wv_pend_fmt  = '0;
    wv_pend_rate = '0;
    wv_sav_fmt   = '0;
    wv_sav_rate  = '0;
    wv_have_data = 1'b0;
    wv_dstart    = '0;
    wv_dlen      = '0;
  endtask

  task automatic wav_close_chunk();
    if (wv_kind == KIND_FMT && wv_clen >= FMT_MIN_LEN) begin
      wv_sav_fmt  = wv_pend_fmt;
      wv_sav_rate = wv_pend_rate;
    end else if (wv_kind == KIND_DATA) begin
      wv_have_data = 1'b1;
      wv_dstart    = wv_cend - 64'(wv_clen);
      wv_dlen      = wv_clen;
    end
  endtask

  task automatic wav_take_byte(input wph_in_t it);
    logic [63:0] k;
    logic [15:0] f_code, f_chans, f_bits;
    wph_out_t    rep;
    if (wv_pos < POS_MAX) begin
      wv_recent = {wv_recent[23:0], it.file_byte};
      case (wv_phase)
        PH_FILE: begin
          if (wv_pos == 64'd3) begin
            wv_sig_ok = (wv_recent == ID_RIFF);
          end else if (wv_pos == 64'(FILE_HDR_LEN - 1)) begin
            wv_sig_ok = wv_sig_ok && (wv_recent == ID_WAVE);
            wv_phase  = PH_HDR;
            wv_cend   = 64'(FILE_HDR_LEN);
          end
        end
        PH_HDR: begin
          k = wv_pos - wv_cend;
          if (k == 64'd3) begin
            if (wv_recent == ID_FMT) wv_kind = KIND_FMT;
            else if (wv_recent == ID_DATA) wv_kind = KIND_DATA;
            else wv_kind = KIND_OTHER;
          end else if (k == 64'd7) begin
            wv_clen = {wv_recent[7:0], wv_recent[15:8], wv_recent[23:16], wv_recent[31:24]};
            wv_cend = wv_pos + 64'd1 + 64'(wv_clen);
            if (wv_clen == 32'd0) begin
              wav_close_chunk();
            end else begin
              wv_phase = PH_BODY;
            end
          end
        end
        PH_BODY: begin
          k = wv_pos - (wv_cend - 64'(wv_clen));
          if (wv_kind == KIND_FMT) begin
            if (k < 64'd4) wv_pend_fmt[8*int'(k[1:0]) +: 8] = it.file_byte;
            else if (k < 64'd8) wv_pend_rate[8*int'(k[1:0]) +: 8] = it.file_byte;
            else if (k == 64'd14 || k == 64'd15)
              wv_pend_fmt[32 + 8*int'(k[0]) +: 8] = it.file_byte;
          end
          if (wv_pos + 64'd1 == wv_cend) begin
            wav_close_chunk();
            wv_phase = wv_clen[0] ? PH_PAD : PH_HDR;
          end
        end
        default: begin
          wv_cend  = wv_pos + 64'd1;
          wv_phase = PH_HDR;
        end
      endcase
      wv_pos++;
    end
    if (it.end_of_file) begin
      f_code  = wv_sav_fmt[15:0];
      f_chans = wv_sav_fmt[31:16];
      f_bits  = wv_sav_fmt[47:32];
      rep = '0;
      if (wv_sig_ok && wv_phase != PH_FILE && f_code == FMT_PCM && f_bits == PCM_BITS &&
          f_chans != 16'd0 && wv_have_data) begin
        rep.valid_pcm16   = 1'b1;
        rep.channel_count = f_chans;
        rep.rate_hz       = wv_sav_rate;
        rep.data_offset   = wv_dstart[31:0];
        rep.data_bytes    = wv_dlen;
        rep.frame_count   = 31'(64'(wv_dlen) / (64'(f_chans) * 64'd2));
      end
      report_q.push_back(rep);
      wav_clear();
    end
  endtask

  task automatic note_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    err_cnt++;
    $display("mismatch in report %0d, %s: got %0h, expected %0h",
             reports_seen, what, got, want);
  endtask

  task automatic check_report(input wph_out_t got);
    wph_out_t want;
    if (report_q.size() == 0) begin
      note_mismatch("report with none pending", 64'(got), 64'd0);
    end else begin
      want = report_q.pop_front();
      if (got.valid_pcm16 !== want.valid_pcm16)
        note_mismatch("valid_pcm16", 64'(got.valid_pcm16), 64'(want.valid_pcm16));
      if (got.channel_count !== want.channel_count)
        note_mismatch("channel_count", 64'(got.channel_count), 64'(want.channel_count));
      if (got.rate_hz !== want.rate_hz)
        note_mismatch("rate_hz", 64'(got.rate_hz), 64'(want.rate_hz));
      if (got.data_offset !== want.data_offset)
        note_mismatch("data_offset", 64'(got.data_offset), 64'(want.data_offset));
      if (got.data_bytes !== want.data_bytes)
        note_mismatch("data_bytes", 64'(got.data_bytes), 64'(want.data_bytes));
      if (got.frame_count !== want.frame_count)
        note_mismatch("frame_count", 64'(got.frame_count), 64'(want.frame_count));
    end
    reports_seen++;
  endtask

  always @(posedge clk_i) begin
    in_fire <= rst_ni && in_valid && in_ready;
    if (rst_ni) begin
      if (in_valid && in_ready) wav_take_byte(in_data);
      if (out_valid && out_ready) check_report(out_data);
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (in_fire || !in_valid)) begin
      if (byte_q.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
        in_valid <= 1'b1;
        in_data  <= byte_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) out_ready <= !rx_hold && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  initial begin
    @(posedge hold_go);
    rx_hold = 1'b1;
    repeat (400) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("tb_top failed");
    $finish;
  end

  task automatic put_id(input logic [31:0] id);
    file_img.push_back(id[31:24]);
    file_img.push_back(id[23:16]);
    file_img.push_back(id[15:8]);
    file_img.push_back(id[7:0]);
  endtask

  task automatic put_le32(input logic [31:0] v);
    file_img.push_back(v[7:0]);
    file_img.push_back(v[15:8]);
    file_img.push_back(v[23:16]);
    file_img.push_back(v[31:24]);
  endtask

  task automatic start_file(input logic [31:0] riff, input logic [31:0] wave);
    file_img.delete();
    put_id(riff);
    put_le32($urandom);
    put_id(wave);
  endtask

  task automatic add_fmt(input int unsigned len, input logic [15:0] code,
                         input logic [15:0] chans, input logic [31:0] rate,
                         input logic [15:0] bits);
    logic [7:0] b;
    put_id(ID_FMT);
    put_le32(len);
    for (int i = 0; i < int'(len); i++) begin
      b = 8'($urandom);
      if (i < 2) b = code[8*i +: 8];
      else if (i < 4) b = chans[8*(i-2) +: 8];
      else if (i < 8) b = rate[8*(i-4) +: 8];
      else if (i == 14 || i == 15) b = bits[8*(i-14) +: 8];
      file_img.push_back(b);
    end
    if (len[0]) file_img.push_back(8'($urandom));
  endtask

  task automatic add_chunk(input logic [31:0] id, input logic [31:0] len,
                           input int unsigned body_n);
    put_id(id);
    put_le32(len);
    repeat (body_n) file_img.push_back(8'($urandom));
    if (32'(body_n) == len && len[0]) file_img.push_back(8'($urandom));
  endtask

  task automatic send_file(input int unsigned cut);
    wph_in_t it;
    while (cut != 0 && file_img.size() > 1) begin
      void'(file_img.pop_back());
      cut--;
    end
    foreach (file_img[i]) begin
      it.file_byte   = file_img[i];
      it.end_of_file = (i == file_img.size() - 1);
      byte_q.push_back(it);
    end
    file_img.delete();
  endtask

  task automatic add_noise_file(input int unsigned n);
    file_img.delete();
    repeat (n) file_img.push_back(8'($urandom));
    send_file(0);
  endtask

  task automatic add_random_file();
    int unsigned sel, len;
    logic [15:0] code, chans, bits;
    sel = $urandom_range(0, 99);
    if (sel < 10) begin
      add_noise_file($urandom_range(1, 24));
    end else begin
      start_file(($urandom_range(0, 15) == 0) ? $urandom : ID_RIFF,
                 ($urandom_range(0, 15) == 0) ? $urandom : ID_WAVE);
      repeat ($urandom_range(1, 4)) begin
        sel = $urandom_range(0, 9);
        if (sel < 4) begin
          case ($urandom_range(0, 9))
            6: len = 18;
            7: len = $urandom_range(0, 15);
            8: len = $urandom_range(17, 40);
            default: len = FMT_MIN_LEN;
          endcase
          code = ($urandom_range(0, 7) == 0) ? 16'($urandom) : FMT_PCM;
          bits = ($urandom_range(0, 7) == 0) ? 16'($urandom) : PCM_BITS;
          case ($urandom_range(0, 9))
            7: chans = 16'd0;
            8: chans = 16'hFFFF;
            9: chans = 16'($urandom);
            default: chans = 16'($urandom_range(1, 8));
          endcase
          add_fmt(len, code, chans, $urandom, bits);
        end else if (sel < 7) begin
          len = $urandom_range(0, 40);
          add_chunk(ID_DATA, len, len);
        end else begin
          len = $urandom_range(0, 12);
          add_chunk($urandom, len, len);
        end
      end
      sel = $urandom_range(0, 9);
      if (sel == 0)
        add_chunk($urandom_range(0, 1) ? ID_DATA : ID_FMT, $urandom, $urandom_range(0, 8));
      send_file((sel == 1) ? $urandom_range(1, 10) : 0);
    end
  endtask

  task automatic wait_drained();
    while (byte_q.size() != 0 || in_valid || report_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    wav_clear();

    // short file, single-byte files
    start_file(ID_RIFF, ID_WAVE);
    send_file(6);
    add_noise_file(1);
    file_img.push_back(8'hFF);
    send_file(0);
    file_img.push_back(8'h00);
    send_file(0);

    // plain valid file
    start_file(ID_RIFF, ID_WAVE);
    add_fmt(16, FMT_PCM, 16'd2, 32'd44100, PCM_BITS);
    add_chunk(ID_DATA, 8, 8);
    send_file(0);

    // bad signatures
    start_file(32'h5249_4647, ID_WAVE);
    add_fmt(16, FMT_PCM, 16'd1, 32'd8000, PCM_BITS);
    add_chunk(ID_DATA, 4, 4);
    send_file(0);
    start_file(ID_RIFF, 32'h5741_5646);
    add_fmt(16, FMT_PCM, 16'd1, 32'd8000, PCM_BITS);
    add_chunk(ID_DATA, 4, 4);
    send_file(0);

    // short fmt alone, then short fmt after a good one
    start_file(ID_RIFF, ID_WAVE);
    add_fmt(15, FMT_PCM, 16'd1, 32'd8000, PCM_BITS);
    add_chunk(ID_DATA, 6, 6);
    send_file(0);
    start_file(ID_RIFF, ID_WAVE);
    add_fmt(18, FMT_PCM, 16'd3, 32'd22050, PCM_BITS);
    add_fmt(14, 16'd3, 16'd7, 32'd1, 16'd8);
    add_chunk(ID_DATA, 12, 12);
    send_file(0);

    // odd chunks with pad, missing final pad
    start_file(ID_RIFF, ID_WAVE);
    add_chunk(32'h4c49_5354, 3, 3);
    add_fmt(16, FMT_PCM, 16'd1, 32'd48000, PCM_BITS);
    add_chunk(ID_DATA, 5, 5);
    send_file(1);

    // empty data chunk, empty other chunk
    start_file(ID_RIFF, ID_WAVE);
    add_fmt(16, FMT_PCM, 16'd1, 32'd16000, PCM_BITS);
    add_chunk(32'h0000_0000, 0, 0);
    add_chunk(ID_DATA, 0, 0);
    send_file(0);

    // truncated data chunk after a complete one, trailing partial header
    start_file(ID_RIFF, ID_WAVE);
    add_fmt(16, FMT_PCM, 16'd2, 32'd11025, PCM_BITS);
    add_chunk(ID_DATA, 10, 10);
    add_chunk(ID_DATA, 100, 7);
    send_file(0);
    start_file(ID_RIFF, ID_WAVE);
    add_fmt(16, FMT_PCM, 16'd1, 32'd11025, PCM_BITS);
    add_chunk(ID_DATA, 2, 2);
    add_chunk(32'hFFFF_FFFF, 0, 0);
    send_file(3);

    // field extremes
    start_file(ID_RIFF, ID_WAVE);
    add_fmt(16, FMT_PCM, 16'hFFFF, 32'hFFFF_FFFF, PCM_BITS);
    add_chunk(ID_DATA, 6, 6);
    send_file(0);
    start_file(ID_RIFF, ID_WAVE);
    add_fmt(16, FMT_PCM, 16'd0, 32'd0, PCM_BITS);
    add_chunk(ID_DATA, 6, 6);
    send_file(0);
    start_file(ID_RIFF, ID_WAVE);
    add_fmt(16, FMT_PCM, 16'd1, 32'd8000, 16'd8);
    add_chunk(ID_DATA, 6, 6);
    send_file(0);
    start_file(ID_RIFF, ID_WAVE);
    add_fmt(16, 16'hFFFF, 16'd1, 32'd8000, PCM_BITS);
    add_chunk(ID_DATA, 6, 6);
    send_file(0);

    // no data chunk, huge truncated chunk
    start_file(ID_RIFF, ID_WAVE);
    add_fmt(16, FMT_PCM, 16'd1, 32'd8000, PCM_BITS);
    send_file(0);
    start_file(ID_RIFF, ID_WAVE);
    add_fmt(16, FMT_PCM, 16'd1, 32'd8000, PCM_BITS);
    add_chunk(ID_DATA, 4, 4);
    add_chunk(32'h6a75_6e6b, 32'hFFFF_FFFF, 5);
    send_file(0);

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    wait_drained();

    // hold off the receiver while short files keep arriving
    @(negedge clk_i);
    hold_go = 1'b1;
    repeat (12) add_noise_file($urandom_range(1, 3));
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 53; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 53; end
        default: begin send_gap_pct = 29; recv_stall_pct = 29; end
      endcase
      repeat (1) add_random_file();
      wait_drained();
    end

    repeat (100) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/wph_pkg.sv
rtl/core/wph_front.sv
rtl/core/wph_queue.sv
rtl/core/wph_back.sv
rtl/core/wav_pcm16_header_parser.sv
rtl/core/wph_checker.sv
dv/tb_top.sv
